/* hdl/assert_macros.svh */
// assertion macros used by the wgcd checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/wgcd_pkg.sv */
// constants and field widths of the wait graph cycle detector
// no dependencies
`timescale 1ns / 1ps

package wgcd_pkg;

  localparam int MODE_W  = 2;
  localparam int ID_W    = 64;
  localparam int COUNT_W = 5;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

endpackage

/* hdl/wgcd_if.sv */
// valid/ready channels for input words and result words
// depends on wgcd_pkg
`timescale 1ns / 1ps

interface wgcd_in_if;
  logic                        valid;
  logic                        ready;
  logic [wgcd_pkg::MODE_W-1:0] mode;
  logic [wgcd_pkg::ID_W-1:0]   from_node;
  logic [wgcd_pkg::ID_W-1:0]   to_node;

  modport source (output valid, mode, from_node, to_node, input ready);
  modport sink   (input valid, mode, from_node, to_node, output ready);
endinterface

interface wgcd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic                         cycle_found;
  logic [wgcd_pkg::COUNT_W-1:0] node_count;

  modport source (output valid, status, cycle_found, node_count, input ready);
  modport sink   (input valid, status, cycle_found, node_count, output ready);
endinterface

/* hdl/wait_graph_cycle_detect_core.sv */
// wait-for graph with cycle check by in-degree peeling
// depends on wgcd_pkg and wgcd_if
// add edge: id table scan, slot allocation, adjacency row update; dropped if the table is full
// check: row sweep for in-degrees, then peeling of zero in-degree nodes, one per read
// clear and unused mode: no graph walk; one word in flight, next taken while a result waits
// reset: async active low, empties the graph at once through slot and row valid bits
`timescale 1ns / 1ps

module wait_graph_cycle_detect_core #(
  parameter int NODES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  wgcd_in_if.sink        item_i,
  wgcd_out_if.source     result_o
);

  localparam int IW = $clog2(NODES);
  localparam int XW = $clog2(NODES + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_ALLOC_A = 4'd2;
  localparam logic [3:0] S_ALLOC_B = 4'd3;
  localparam logic [3:0] S_ADJ_WR  = 4'd4;
  localparam logic [3:0] S_DEG     = 4'd5;
  localparam logic [3:0] S_PEEL    = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;

  function automatic logic [IW-1:0] lowest(input logic [NODES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  // memories
  logic [wgcd_pkg::ID_W-1:0] node_mem [NODES];
  logic [NODES-1:0]          adj_mem  [NODES];

  logic                      node_we, node_re;
  logic [IW-1:0]             node_waddr, node_raddr;
  logic [wgcd_pkg::ID_W-1:0] node_wdata;
  logic [wgcd_pkg::ID_W-1:0] node_rd_q;

  logic                      adj_we, adj_re;
  logic [IW-1:0]             adj_waddr, adj_raddr;
  logic [NODES-1:0]          adj_wdata;
  logic [NODES-1:0]          adj_rd_q;
  logic                      adj_rv_q;

  // control state
  logic [3:0]       state_q, state_d;
  logic [XW-1:0]    idx_q, idx_d;
  logic             sv_q, sv_d;
  logic [IW-1:0]    sidx_q, sidx_d;
  logic             pv_q, pv_d;
  logic [NODES-1:0] slot_valid_q, slot_valid_d;
  logic [NODES-1:0] row_vld_q, row_vld_d;
  logic [XW-1:0]    count_q, count_d;
  logic             out_vld_q, out_vld_d;

  // working data
  logic [wgcd_pkg::ID_W-1:0]    from_q, from_d, to_q, to_d;
  logic                         hit_a_q, hit_a_d, hit_b_q, hit_b_d;
  logic [IW-1:0]                slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic                         new_b_q, new_b_d;
  logic [NODES-1:0]             left_q, left_d;
  logic [XW-1:0]                indeg_q [NODES];
  logic [XW-1:0]                indeg_d [NODES];
  logic                         res_status_q, res_status_d;
  logic                         res_cyc_q, res_cyc_d;
  logic                         o_status_q, o_status_d;
  logic                         o_cyc_q, o_cyc_d;
  logic [wgcd_pkg::COUNT_W-1:0] o_count_q, o_count_d;

  logic [NODES-1:0]             row, zero_vec, pending, bit_b;
  logic [IW-1:0]                free1, free2, pick, a_sel, b_sel;
  logic                         same_id, need_a, need_b, tbl_full;
  logic [XW:0]                  need_sum;
  logic [XW+wgcd_pkg::COUNT_W-1:0] count_ext;

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_raddr];
      adj_rv_q <= row_vld_q[adj_raddr];
    end
  end

  assign row = adj_rv_q ? adj_rd_q : '0;

  assign free1    = lowest(~slot_valid_q);
  assign free2    = lowest(~slot_valid_q & ~({{(NODES-1){1'b0}}, 1'b1} << free1));
  assign same_id  = (from_q == to_q);
  assign need_a   = !hit_a_q;
  assign need_b   = !hit_b_q && !(need_a && same_id);
  assign need_sum = {1'b0, count_q} + (XW+1)'(need_a) + (XW+1)'(need_b);
  assign tbl_full = need_sum > (XW+1)'(NODES);
  assign a_sel    = hit_a_q ? slot_a_q : free1;
  assign b_sel    = hit_b_q ? slot_b_q : ((need_a && same_id) ? a_sel :
                                          (need_a ? free2 : free1));
  assign bit_b    = {{(NODES-1){1'b0}}, 1'b1} << slot_b_q;

  always_comb begin
    for (int j = 0; j < NODES; j++) zero_vec[j] = (indeg_q[j] == '0);
  end
  assign pending = left_q & zero_vec;
  assign pick    = lowest(pending);

  assign count_ext = {{wgcd_pkg::COUNT_W{1'b0}}, count_q};

  assign item_i.ready         = (state_q == S_IDLE);
  assign result_o.valid       = out_vld_q;
  assign result_o.status      = o_status_q;
  assign result_o.cycle_found = o_cyc_q;
  assign result_o.node_count  = o_count_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    sv_d         = 1'b0;
    sidx_d       = idx_q[IW-1:0];
    pv_d         = 1'b0;
    slot_valid_d = slot_valid_q;
    row_vld_d    = row_vld_q;
    count_d      = count_q;
    out_vld_d    = out_vld_q;
    from_d       = from_q;
    to_d         = to_q;
    hit_a_d      = hit_a_q;
    hit_b_d      = hit_b_q;
    slot_a_d     = slot_a_q;
    slot_b_d     = slot_b_q;
    new_b_d      = new_b_q;
    left_d       = left_q;
    indeg_d      = indeg_q;
    res_status_d = res_status_q;
    res_cyc_d    = res_cyc_q;
    o_status_d   = o_status_q;
    o_cyc_d      = o_cyc_q;
    o_count_d    = o_count_q;

    node_we    = 1'b0;
    node_waddr = a_sel;
    node_wdata = from_q;
    node_re    = 1'b0;
    node_raddr = idx_q[IW-1:0];
    adj_we     = 1'b0;
    adj_waddr  = slot_a_q;
    adj_wdata  = row | bit_b;
    adj_re     = 1'b0;
    adj_raddr  = idx_q[IW-1:0];

    if (out_vld_q && result_o.ready) out_vld_d = 1'b0;

    // id table compare on returning read data
    if (sv_q && state_q == S_SCAN && slot_valid_q[sidx_q]) begin
      if (node_rd_q == from_q) begin
        hit_a_d  = 1'b1;
        slot_a_d = sidx_q;
      end
      if (node_rd_q == to_q) begin
        hit_b_d  = 1'b1;
        slot_b_d = sidx_q;
      end
    end

    // in-degree build
    if (sv_q && state_q == S_DEG) begin
      for (int j = 0; j < NODES; j++) indeg_d[j] = indeg_q[j] + XW'(row[j]);
    end

    case (state_q)
      S_IDLE: begin
        if (item_i.valid) begin
          res_status_d = 1'b0;
          res_cyc_d    = 1'b0;
          idx_d        = '0;
          case (item_i.mode)
            wgcd_pkg::MODE_ADD: begin
              from_d  = item_i.from_node;
              to_d    = item_i.to_node;
              hit_a_d = 1'b0;
              hit_b_d = 1'b0;
              state_d = S_SCAN;
            end
            wgcd_pkg::MODE_CLEAR: begin
              slot_valid_d = '0;
              row_vld_d    = '0;
              count_d      = '0;
              state_d      = S_FIN;
            end
            wgcd_pkg::MODE_CHECK: begin
              left_d = slot_valid_q;
              for (int j = 0; j < NODES; j++) indeg_d[j] = '0;
              state_d = S_DEG;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_q != XW'(NODES)) begin
          node_re = 1'b1;
          sv_d    = 1'b1;
          idx_d   = idx_q + XW'(1);
        end else begin
          state_d = S_ALLOC_A;
        end
      end
      S_ALLOC_A: begin
        if (tbl_full) begin
          res_status_d = 1'b1;
          state_d      = S_FIN;
        end else begin
          slot_a_d = a_sel;
          slot_b_d = b_sel;
          new_b_d  = need_b;
          if (need_a) begin
            node_we             = 1'b1;
            slot_valid_d[a_sel] = 1'b1;
            count_d             = count_q + XW'(1);
          end
          state_d = S_ALLOC_B;
        end
      end
      S_ALLOC_B: begin
        adj_re    = 1'b1;
        adj_raddr = slot_a_q;
        if (new_b_q) begin
          node_we                = 1'b1;
          node_waddr             = slot_b_q;
          node_wdata             = to_q;
          slot_valid_d[slot_b_q] = 1'b1;
          count_d                = count_q + XW'(1);
        end
        state_d = S_ADJ_WR;
      end
      S_ADJ_WR: begin
        adj_we              = 1'b1;
        row_vld_d[slot_a_q] = 1'b1;
        state_d             = S_FIN;
      end
      S_DEG: begin
        if (idx_q != XW'(NODES)) begin
          adj_re = 1'b1;
          sv_d   = 1'b1;
          idx_d  = idx_q + XW'(1);
        end else begin
          state_d = S_PEEL;
        end
      end
      S_PEEL: begin
        if (pv_q) begin
          for (int j = 0; j < NODES; j++) indeg_d[j] = indeg_q[j] - XW'(row[j]);
        end
        if (pending != '0) begin
          adj_re       = 1'b1;
          adj_raddr    = pick;
          left_d[pick] = 1'b0;
          pv_d         = 1'b1;
        end else if (!pv_q) begin
          res_cyc_d = (left_q != '0);
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_q || result_o.ready) begin
          out_vld_d  = 1'b1;
          o_status_d = res_status_q;
          o_cyc_d    = res_cyc_q;
          o_count_d  = count_ext[wgcd_pkg::COUNT_W-1:0];
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      sv_q         <= 1'b0;
      pv_q         <= 1'b0;
      slot_valid_q <= '0;
      row_vld_q    <= '0;
      count_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      sv_q         <= sv_d;
      pv_q         <= pv_d;
      slot_valid_q <= slot_valid_d;
      row_vld_q    <= row_vld_d;
      count_q      <= count_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q       <= sidx_d;
    from_q       <= from_d;
    to_q         <= to_d;
    hit_a_q      <= hit_a_d;
    hit_b_q      <= hit_b_d;
    slot_a_q     <= slot_a_d;
    slot_b_q     <= slot_b_d;
    new_b_q      <= new_b_d;
    left_q       <= left_d;
    indeg_q      <= indeg_d;
    res_status_q <= res_status_d;
    res_cyc_q    <= res_cyc_d;
    o_status_q   <= o_status_d;
    o_cyc_q      <= o_cyc_d;
    o_count_q    <= o_count_d;
  end

endmodule

/* hdl/wgcd_checker.sv */
// port-level assertions for the wait graph cycle detector, bound to the top level
// depends on assert_macros.svh, wgcd_pkg and wait_graph_cycle_detect_core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wgcd_checker #(
  parameter int NODES = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         status_i,
  input logic                         cycle_found_i,
  input logic [wgcd_pkg::COUNT_W-1:0] node_count_i
);

  // a stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // one word in flight: no accept right after an accept
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // a dropped edge never comes with a cycle report
  `ASSERT_PROP(a_status_excl, clk_i, rst_ni, out_valid_i |-> !(status_i && cycle_found_i))

  // an empty graph has no cycle
  `ASSERT_PROP(a_cycle_nonempty, clk_i, rst_ni, out_valid_i && cycle_found_i && (NODES < 32) |-> node_count_i != '0)

endmodule

bind wait_graph_cycle_detect_core wgcd_checker #(.NODES(NODES)) u_wgcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .status_i      (result_o.status),
  .cycle_found_i (result_o.cycle_found),
  .node_count_i  (result_o.node_count)
);

/* sim/wait_graph_cycle_detect_core_tb.sv */
// self-checking testbench for wait_graph_cycle_detect_core: add edge, clear, check, spare
// mode words in, graph predictor on every accepted word, result words compared field by field
// depends on wgcd_pkg, wgcd_in_if, wgcd_out_if and wait_graph_cycle_detect_core
`timescale 1ns / 1ps

module wait_graph_cycle_detect_core_tb;

  localparam int NODES = 16;
  localparam int MODE_W = wgcd_pkg::MODE_W;
  localparam int ID_W = wgcd_pkg::ID_W;
  localparam int COUNT_W = wgcd_pkg::COUNT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 700;
  localparam int HOLD_AFTER = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    bit                pause;
  } graph_op_t;

  typedef struct {
    logic               status;
    logic               cycle_found;
    logic [COUNT_W-1:0] node_count;
  } graph_reply_t;

  logic clk_i;
  logic rst_ni;

  wgcd_in_if  item_if ();
  wgcd_out_if result_if ();

  wait_graph_cycle_detect_core #(.NODES(NODES)) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source)
  );

  // graph predictor state
  logic [ID_W-1:0]  node_tab  [NODES];
  logic [NODES-1:0] wait_rows [NODES];
  logic [NODES-1:0] live_slots;
  int unsigned      live_count;

  graph_op_t    graph_ops_q [$];
  graph_reply_t graph_replies_q [$];
  graph_op_t    next_op;
  graph_op_t    seen_op;
  graph_reply_t want;

  int errors = 0;
  int tick = 0;
  int accepted_words = 0;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit hold_done;
  wire calm = (tick[8:7] == 2'b00);

  function automatic void graph_clear();
    live_slots = '0;
    live_count = 0;
    for (int i = 0; i < NODES; i++) begin
      node_tab[i]  = '0;
      wait_rows[i] = '0;
    end
  endfunction

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < NODES; i++)
      if (live_slots[i] && node_tab[i] == id) return i;
    return -1;
  endfunction

  function automatic int claim_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < NODES; i++)
      if (!live_slots[i]) begin
        node_tab[i]   = id;
        live_slots[i] = 1'b1;
        live_count++;
        return i;
      end
    return -1;
  endfunction

  // returns 1 when the edge is dropped for lack of free slots
  function automatic logic add_wait_edge(logic [ID_W-1:0] src, logic [ID_W-1:0] dst);
    int a;
    int b;
    int unsigned need;
    a = slot_of(src);
    b = slot_of(dst);
    need = 0;
    if (a < 0) need++;
    if (b < 0 && !(a < 0 && src == dst)) need++;
    if (live_count + need > NODES) return 1'b1;
    if (a < 0) a = claim_slot(src);
    if (b < 0) b = (src == dst) ? a : claim_slot(dst);
    wait_rows[a][b] = 1'b1;
    return 1'b0;
  endfunction

  // peel nodes with no incoming edge until nothing moves
  function automatic logic graph_has_loop();
    logic [NODES-1:0] left;
    logic [NODES-1:0] targets;
    logic [NODES-1:0] peel;
    left = live_slots;
    do begin
      targets = '0;
      for (int i = 0; i < NODES; i++)
        if (left[i]) targets |= wait_rows[i];
      peel = left & ~targets;
      left &= ~peel;
    end while (peel != '0);
    return |left;
  endfunction

  function automatic graph_reply_t graph_apply(graph_op_t op);
    graph_reply_t r;
    r.status = 1'b0;
    r.cycle_found = 1'b0;
    case (op.mode)
      wgcd_pkg::MODE_ADD:   r.status = add_wait_edge(op.src, op.dst);
      wgcd_pkg::MODE_CLEAR: graph_clear();
      wgcd_pkg::MODE_CHECK: r.cycle_found = graph_has_loop();
      default: ;
    endcase
    r.node_count = COUNT_W'(live_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  task automatic push_op(logic [MODE_W-1:0] mode, logic [ID_W-1:0] src,
                         logic [ID_W-1:0] dst);
    graph_op_t op;
    op.mode  = mode;
    op.src   = src;
    op.dst   = dst;
    op.pause = 1'b0;
    graph_ops_q.insert(graph_ops_q.size(), op);
  endtask

  task automatic push_pause();
    graph_op_t op;
    op.mode  = wgcd_pkg::MODE_ADD;
    op.src   = '0;
    op.dst   = '0;
    op.pause = 1'b1;
    graph_ops_q.insert(graph_ops_q.size(), op);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) tick <= tick + 1;

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid     <= 1'b0;
      item_if.mode      <= wgcd_pkg::MODE_ADD;
      item_if.from_node <= '0;
      item_if.to_node   <= '0;
      send_gap          <= 0;
    end else if (!item_if.valid || item_if.ready) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        item_if.valid <= 1'b0;
      end else if (graph_ops_q.size() == 0) begin
        item_if.valid <= 1'b0;
      end else if (graph_ops_q[0].pause) begin
        item_if.valid <= 1'b0;
        if (!item_if.valid && graph_replies_q.size() == 0) graph_ops_q.delete(0);
      end else begin
        next_op = graph_ops_q[0];
        graph_ops_q.delete(0);
        item_if.valid     <= 1'b1;
        item_if.mode      <= next_op.mode;
        item_if.from_node <= next_op.src;
        item_if.to_node   <= next_op.dst;
        send_gap          <= calm ? 0 : pick_gap();
      end
    end
  end

  // result ready with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      stall_left      <= 0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (!hold_done && accepted_words >= HOLD_AFTER) begin
      hold_done       <= 1'b1;
      hold_left       <= HOLD_CYCLES;
      result_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      stall_left      <= calm ? 0 : pick_gap();
    end
  end

  // result check first, then prediction of the word accepted at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (graph_replies_q.size() == 0) begin
          $display("%0t: unexpected result word status %0d cycle_found %0d node_count %0d",
                   $time, result_if.status, result_if.cycle_found, result_if.node_count);
          errors++;
        end else begin
          want = graph_replies_q[0];
          graph_replies_q.delete(0);
          if (result_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     result_if.status);
            errors++;
          end
          if (result_if.cycle_found !== want.cycle_found) begin
            $display("%0t: cycle_found expected %0d actual %0d", $time, want.cycle_found,
                     result_if.cycle_found);
            errors++;
          end
          if (result_if.node_count !== want.node_count) begin
            $display("%0t: node_count expected %0d actual %0d", $time, want.node_count,
                     result_if.node_count);
            errors++;
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        seen_op.mode  = item_if.mode;
        seen_op.src   = item_if.from_node;
        seen_op.dst   = item_if.to_node;
        seen_op.pause = 1'b0;
        graph_replies_q.insert(graph_replies_q.size(), graph_apply(seen_op));
        accepted_words <= accepted_words + 1;
      end
    end
  end

  initial begin
    while (tick < CYCLE_LIMIT) @(posedge clk_i);
    $display("wait_graph_cycle_detect_core_tb: FAIL");
    $finish;
  end

  initial begin
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
    logic [ID_W-1:0] id_c;
    logic [ID_W-1:0] id_pool [24];
    int issued;
    int seg;
    int k;
    int len;
    int x;
    int y;
    int r;
    bit big;

    rst_ni = 1'b0;
    graph_clear();

    id_a = rand_id();
    id_b = rand_id();
    id_c = rand_id();

    // empty graph, spare mode, extreme ids, self-loop on a known id
    push_op(wgcd_pkg::MODE_CHECK, '1, '1);
    push_op(MODE_SPARE, rand_id(), rand_id());
    push_op(wgcd_pkg::MODE_ADD, '0, '1);
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_op(wgcd_pkg::MODE_ADD, '1, '1);
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_op(wgcd_pkg::MODE_CLEAR, '1, '0);
    // self-loop on an unseen id needs one slot
    push_op(wgcd_pkg::MODE_ADD, id_a, id_a);
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_op(wgcd_pkg::MODE_CLEAR, '0, '0);
    // duplicate edge, then closing a three-node loop
    push_op(wgcd_pkg::MODE_ADD, id_a, id_b);
    push_op(wgcd_pkg::MODE_ADD, id_a, id_b);
    push_op(wgcd_pkg::MODE_ADD, id_b, id_c);
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_op(wgcd_pkg::MODE_ADD, id_c, id_a);
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_op(wgcd_pkg::MODE_CLEAR, '0, '0);
    // fill the table to 15, then drops and the last free slot
    for (int i = 0; i < 7; i++)
      push_op(wgcd_pkg::MODE_ADD, ID_W'(256 + 2 * i), ID_W'(257 + 2 * i));
    push_op(wgcd_pkg::MODE_ADD, ID_W'(256), ID_W'(300));
    push_op(wgcd_pkg::MODE_ADD, ID_W'(301), ID_W'(302));
    push_op(wgcd_pkg::MODE_ADD, ID_W'(303), ID_W'(303));
    push_op(wgcd_pkg::MODE_ADD, ID_W'(257), ID_W'(304));
    push_op(wgcd_pkg::MODE_CHECK, '0, '0);
    push_pause();

    issued = 0;
    seg = 0;
    while (issued < RANDOM_WORDS) begin
      seg++;
      if (seg % 12 == 5) push_pause();
      if ($urandom_range(0, 3) != 0) begin
        push_op(wgcd_pkg::MODE_CLEAR, rand_id(), rand_id());
        issued++;
      end
      big = ($urandom_range(0, 7) == 0);
      k = big ? $urandom_range(14, 20) : $urandom_range(2, 8);
      for (int i = 0; i < k; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) id_pool[i] = '0;
        else if (r == 1) id_pool[i] = '1;
        else if (r == 2) id_pool[i] = ID_W'($urandom_range(0, 31));
        else id_pool[i] = rand_id();
      end
      len = big ? $urandom_range(20, 40) : $urandom_range(6, 20);
      for (int j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          // mostly forward edges so that loops stay the exception
          x = $urandom_range(0, k - 1);
          if ($urandom_range(0, 3) != 0 && x < k - 1) y = $urandom_range(x + 1, k - 1);
          else y = $urandom_range(0, k - 1);
          push_op(wgcd_pkg::MODE_ADD, id_pool[x], id_pool[y]);
          issued++;
        end else if (r < 88) begin
          push_op(wgcd_pkg::MODE_CHECK, rand_id(), rand_id());
          issued++;
        end else if (r < 93) begin
          push_op(MODE_SPARE, rand_id(), rand_id());
        end else begin
          if (r[0])
            push_op(wgcd_pkg::MODE_ADD, rand_id(), id_pool[$urandom_range(0, k - 1)]);
          else
            push_op(wgcd_pkg::MODE_ADD, id_pool[$urandom_range(0, k - 1)], rand_id());
          issued++;
        end
      end
      push_op(wgcd_pkg::MODE_CHECK, rand_id(), rand_id());
      issued++;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (graph_ops_q.size() != 0 || item_if.valid) @(posedge clk_i);
    while (graph_replies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (graph_replies_q.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, graph_replies_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("wait_graph_cycle_detect_core_tb: PASS");
    end else begin
      $display("wait_graph_cycle_detect_core_tb: FAIL");
    end
    $finish;
  end

endmodule
